### rtl/tbc_pkg.sv
// Package for the tilt balance controller: widths, register indices, atan table, states.
`default_nettype none
package tbc_pkg;
  localparam int FracBits = 16;
  localparam int AtanSteps = 16;
  localparam int TableFrac = 24;
  localparam int StepW = 5;

  localparam logic [2:0] RegFb1 = 3'd0;
  localparam logic [2:0] RegFb2 = 3'd1;
  localparam logic [2:0] RegEc0 = 3'd2;
  localparam logic [2:0] RegEc1 = 3'd3;
  localparam logic [2:0] RegEc2 = 3'd4;
  localparam logic [2:0] RegAlpha = 3'd5;
  localparam logic [2:0] RegPeriod = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_GYRO, ST_LP, ST_HP, ST_EST,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_OUT
  } state_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [35:0] atan_entry(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_entry = 36'sd754974720;
      5'd1: atan_entry = 36'sd445687602;
      5'd2: atan_entry = 36'sd235489088;
      5'd3: atan_entry = 36'sd119537938;
      5'd4: atan_entry = 36'sd60000934;
      5'd5: atan_entry = 36'sd30029717;
      5'd6: atan_entry = 36'sd15018523;
      5'd7: atan_entry = 36'sd7509720;
      5'd8: atan_entry = 36'sd3754917;
      5'd9: atan_entry = 36'sd1877466;
      5'd10: atan_entry = 36'sd938734;
      5'd11: atan_entry = 36'sd469367;
      5'd12: atan_entry = 36'sd234684;
      5'd13: atan_entry = 36'sd117342;
      5'd14: atan_entry = 36'sd58671;
      5'd15: atan_entry = 36'sd29335;
      default: atan_entry = 36'sd0;
    endcase
  endfunction

  // saturate a wide value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -68'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

### rtl/tilt_balance_controller.sv
// Top level of the tilt balance controller: sequencer, CORDIC and filter datapath.
//
// Usage: one input word on s_axis carries an IMU sample; one output word on
// m_axis carries the two drives and the tilt estimate. Configuration writes
// go through cfg_we/cfg_index/cfg_data while the block is idle; the user must
// keep to this, as the block itself does not enforce it. Each word passes
// from acceptance to output valid through 16 CORDIC iterations on a shared
// add/shift unit, eight steps through the single registered multiplier
// (gyro, low-pass, high-pass, five controller terms), each with an operand
// and a product phase, then an estimate state and an output state. A word
// with stop set skips the five controller terms. s_axis_tready is high only
// in the idle state, so a new word is taken only after the previous one has left the output state. The result
// sits in an output register; while the receiver stalls it holds, one more
// word is accepted and computed, and that word then waits in the output
// state with s_axis_tready low until the held word is taken.
// Reset (rst, synchronous) clears all filter and controller history, loads
// the default coefficients and leaves the block idle and ready.
`default_nettype none
module tilt_balance_controller (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // accel_y[15:0], accel_z[31:16], gyro_rate[63:32], target_tilt[95:64],
  // steer_offset[127:96]
  input  wire logic [127:0] s_axis_tdata,
  // stop[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // left_drive[31:0], right_drive[63:32], tilt_estimate[95:64]
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  tbc_pkg::state_t state, state_next;

  logic signed [31:0] fb1, fb2, ec0, ec1, ec2;
  logic [16:0] alpha, period;
  logic signed [31:0] lp_last, gint, hp_in, hp_out, e1, e2, y1, y2;

  logic signed [15:0] ay, az;
  logic signed [31:0] rate, target, offset;
  logic stop;

  logic signed [35:0] cx, cy, ang;
  logic [tbc_pkg::StepW-1:0] step;
  logic phase;
  logic signed [31:0] lp, hp, est, err;
  logic signed [67:0] tacc;
  logic signed [67:0] acc;

  logic signed [33:0] ma;
  logic signed [32:0] mb;
  logic signed [67:0] mp;
  logic signed [35:0] dx, dy;
  logic signed [67:0] ang_r, tclamp;
  logic signed [67:0] one;

  tbc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign s_axis_tready = (state == tbc_pkg::ST_IDLE);
  assign one = 68'sd1 <<< tbc_pkg::FracBits;

  // CORDIC shift terms, rounded angle minus 90 degrees, and the controller sum clamped to +/-1
  always_comb begin
    dx = cy >>> step;
    dy = cx >>> step;
    ang_r = (68'(ang) + (68'sd1 <<< (tbc_pkg::TableFrac - tbc_pkg::FracBits - 1))) >>>
            (tbc_pkg::TableFrac - tbc_pkg::FracBits);
    acc = ang_r - 68'sd90 * one;
    if (tacc >= one) tclamp = one;
    else if (tacc <= -one) tclamp = -one;
    else tclamp = tacc;
  end

  // select multiplier operands per step
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      tbc_pkg::ST_GYRO: begin ma = 34'(rate); mb = 33'($signed({1'b0, period})); end
      tbc_pkg::ST_LP: begin
        ma = 34'(acc - 68'(lp_last)); mb = 33'($signed({1'b0, alpha}));
      end
      tbc_pkg::ST_HP: begin
        ma = 34'(68'(hp_out) + 68'(gint) - 68'(hp_in)); mb = 33'($signed({1'b0, alpha}));
      end
      tbc_pkg::ST_T1: begin ma = 34'(fb1); mb = 33'(y1); end
      tbc_pkg::ST_T2: begin ma = 34'(fb2); mb = 33'(y2); end
      tbc_pkg::ST_T3: begin ma = 34'(ec0); mb = 33'(err); end
      tbc_pkg::ST_T4: begin ma = 34'(ec1); mb = 33'(e1); end
      tbc_pkg::ST_T5: begin ma = 34'(ec2); mb = 33'(e2); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // next state: each multiply step has an operand phase and a product phase
  always_comb begin
    state_next = state;
    case (state)
      tbc_pkg::ST_IDLE: if (s_axis_tvalid) state_next = tbc_pkg::ST_CORDIC;
      tbc_pkg::ST_CORDIC:
        if (step == tbc_pkg::StepW'(tbc_pkg::AtanSteps - 1)) state_next = tbc_pkg::ST_GYRO;
      tbc_pkg::ST_GYRO: if (phase) state_next = tbc_pkg::ST_LP;
      tbc_pkg::ST_LP: if (phase) state_next = tbc_pkg::ST_HP;
      tbc_pkg::ST_HP: if (phase) state_next = tbc_pkg::ST_EST;
      tbc_pkg::ST_EST: state_next = stop ? tbc_pkg::ST_OUT : tbc_pkg::ST_T1;
      tbc_pkg::ST_T1: if (phase) state_next = tbc_pkg::ST_T2;
      tbc_pkg::ST_T2: if (phase) state_next = tbc_pkg::ST_T3;
      tbc_pkg::ST_T3: if (phase) state_next = tbc_pkg::ST_T4;
      tbc_pkg::ST_T4: if (phase) state_next = tbc_pkg::ST_T5;
      tbc_pkg::ST_T5: if (phase) state_next = tbc_pkg::ST_OUT;
      tbc_pkg::ST_OUT: if (!m_axis_tvalid || m_axis_tready) state_next = tbc_pkg::ST_IDLE;
      default: state_next = tbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tbc_pkg::ST_IDLE;
    else state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fb1 <= -32'sd118797; fb2 <= 32'sd53261; ec0 <= -32'sd257207;
      ec1 <= 32'sd463602; ec2 <= -32'sd208581;
      alpha <= 17'd59578; period <= 17'd328;
    end else if (cfg_we) begin
      case (cfg_index)
        tbc_pkg::RegFb1: fb1 <= cfg_data;
        tbc_pkg::RegFb2: fb2 <= cfg_data;
        tbc_pkg::RegEc0: ec0 <= cfg_data;
        tbc_pkg::RegEc1: ec1 <= cfg_data;
        tbc_pkg::RegEc2: ec2 <= cfg_data;
        tbc_pkg::RegAlpha: alpha <= cfg_data[16:0];
        tbc_pkg::RegPeriod: period <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // datapath and history
  always_ff @(posedge clk) begin
    if (rst) begin
      lp_last <= '0; gint <= '0; hp_in <= '0; hp_out <= '0;
      e1 <= '0; e2 <= '0; y1 <= '0; y2 <= '0;
      m_axis_tvalid <= 1'b0; step <= '0; phase <= 1'b0;
    end else begin
      // load a new result word, or drop the one just taken
      if (state == tbc_pkg::ST_OUT && (!m_axis_tvalid || m_axis_tready))
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready)
        m_axis_tvalid <= 1'b0;
      if (state != state_next) phase <= 1'b0;
      else phase <= ~phase;
      case (state)
        tbc_pkg::ST_IDLE: begin
          step <= '0;
          if (s_axis_tvalid) begin
            ay <= s_axis_tdata[15:0]; az <= s_axis_tdata[31:16];
            rate <= s_axis_tdata[63:32]; target <= s_axis_tdata[95:64];
            offset <= s_axis_tdata[127:96]; stop <= s_axis_tuser;
            // quadrant fold: rotate by 180 for negative z
            if (s_axis_tdata[31]) begin
              cx <= -(36'($signed(s_axis_tdata[31:16])) <<< 16);
              cy <= -(36'($signed(s_axis_tdata[15:0])) <<< 16);
              ang <= s_axis_tdata[15] ? -36'sd3019898880 : 36'sd3019898880;
            end else begin
              cx <= 36'($signed(s_axis_tdata[31:16])) <<< 16;
              cy <= 36'($signed(s_axis_tdata[15:0])) <<< 16;
              ang <= '0;
            end
          end
        end
        tbc_pkg::ST_CORDIC: begin
          // iterate one rotation per cycle; zero vector keeps angle zero
          step <= step + 1'b1;
          if (ay == 16'sd0 && az == 16'sd0) ang <= '0;
          else if (!cy[35]) begin
            cx <= cx + dx; cy <= cy - dy; ang <= ang + tbc_pkg::atan_entry(step);
          end else begin
            cx <= cx - dx; cy <= cy + dy; ang <= ang - tbc_pkg::atan_entry(step);
          end
        end
        tbc_pkg::ST_GYRO: if (phase) gint <= tbc_pkg::sat32(68'(gint) + mp);
        tbc_pkg::ST_LP: if (phase) lp <= tbc_pkg::sat32(68'(lp_last) + mp);
        tbc_pkg::ST_HP: if (phase) hp <= tbc_pkg::sat32(mp);
        tbc_pkg::ST_EST: begin
          est <= tbc_pkg::sat32(68'(lp) + 68'(hp));
          err <= tbc_pkg::sat32(68'(target) - (68'(lp) + 68'(hp) > 68'sd2147483647 ?
                 68'sd2147483647 : (68'(lp) + 68'(hp) < -68'sd2147483648 ?
                 -68'sd2147483648 : 68'(lp) + 68'(hp))));
          lp_last <= lp; hp_in <= gint; hp_out <= hp;
          tacc <= '0;
        end
        tbc_pkg::ST_T1: if (phase) tacc <= tacc - mp;
        tbc_pkg::ST_T2: if (phase) tacc <= tacc - mp;
        tbc_pkg::ST_T3, tbc_pkg::ST_T4, tbc_pkg::ST_T5: if (phase) tacc <= tacc + mp;
        tbc_pkg::ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata[95:64] <= est;
            e2 <= e1; e1 <= err; y2 <= y1;
            if (stop) begin
              m_axis_tdata[63:0] <= '0;
            end else begin
              y1 <= tclamp[31:0];
              m_axis_tdata[31:0] <= tbc_pkg::sat32(68'(offset) - tclamp);
              m_axis_tdata[63:32] <= tbc_pkg::sat32(tclamp + 68'(offset));
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/tbc_mul.sv
// Shared fixed-point multiplier: 34x33 signed product, rounded, registered.
`default_nettype none
module tbc_mul (
  input  wire logic               clk,
  input  wire logic signed [33:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [67:0]      p
);
  logic signed [67:0] prod;

  // round to nearest, ties up, then drop fraction bits
  always_comb begin
    prod = 68'(a) * 68'(b) + 68'(1 << (tbc_pkg::FracBits - 1));
  end

  always_ff @(posedge clk) begin
    p <= prod >>> tbc_pkg::FracBits;
  end
endmodule
`default_nettype wire

### rtl/tbc_checker.sv
// Port-level checker for the tilt balance controller, bound to the top level.
`default_nettype none
module tbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata
);
  // no input accepted in the cycle right after one is accepted
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");
  // a result never appears the cycle after acceptance
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");
  // stalled output holds its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // after reset, output is empty
  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind tilt_balance_controller tbc_checker u_tbc_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### test/tilt_balance_controller_test.sv
// Self-checking testbench for the tilt balance controller: directed and random IMU words.
`default_nettype none
module tilt_balance_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbc_pkg::*;

  typedef struct packed {
    logic signed [31:0] steer_offset;
    logic signed [31:0] target_tilt;
    logic signed [31:0] gyro_rate;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
  } imu_word_t;

  typedef struct packed {
    logic [31:0] tilt_estimate;
    logic [31:0] right_drive;
    logic [31:0] left_drive;
  } drive_word_t;

  typedef struct {
    imu_word_t   imu;
    logic        stop;
    logic        typed;
    drive_word_t want;
  } directed_row_t;

  typedef struct {
    logic [31:0] fb1, fb2, ec0, ec1, ec2;
    logic [31:0] alpha, period;
  } gains_t;

  localparam longint AtanDeg24 [16] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };
  localparam longint One = 64'sd65536;
  localparam int PhaseCount = 8;
  localparam int WordsPerPhase = 228;
  localparam int DrainCycles = 40;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = RegFb1;
  logic [31:0]  cfg_data = '0;

  tilt_balance_controller uut (.*);

  // Controller model: gains and filter/controller history
  longint fb1_gain, fb2_gain, ec0_gain, ec1_gain, ec2_gain, alpha_gain, period_gain;
  longint lowpass_q, gyro_sum, highpass_in_q, highpass_out_q;
  longint err_hist [2];
  longint duty_hist [2];

  drive_word_t expected_drives [$];
  int fault_count = 0;
  int words_checked = 0;
  int stop_words = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout waiting for drive words");
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product rounded half up back to 16 fraction bits
  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  // vectoring CORDIC angle of (az, ay) in degrees, 16 fraction bits
  function automatic longint accel_angle(longint ay, longint az);
    longint x, y, ang, dx, dy;
    if (ay == 0 && az == 0) return 0;
    x = az * 65536;
    y = ay * 65536;
    ang = 0;
    // left half plane: rotate by 180 degrees first
    if (az < 0) begin
      x = -x;
      y = -y;
      ang = (ay >= 0) ? 64'sd180 * 64'sd16777216 : -64'sd180 * 64'sd16777216;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        ang += AtanDeg24[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= AtanDeg24[i];
      end
    end
    return (ang + 64'sd128) >>> 8;
  endfunction

  function automatic void clear_history();
    lowpass_q = 0;
    gyro_sum = 0;
    highpass_in_q = 0;
    highpass_out_q = 0;
    err_hist = '{0, 0};
    duty_hist = '{0, 0};
  endfunction

  // advance the controller model by one IMU word
  function automatic drive_word_t predict_drives(imu_word_t w, logic stop);
    longint acc, lp, hp, est, err, e1, e2, y1, y2, t, duty, offset;
    drive_word_t r;
    offset = w.steer_offset;
    acc = accel_angle(w.accel_y, w.accel_z) - 90 * One;
    gyro_sum = clip32(gyro_sum + qmul(w.gyro_rate, period_gain));
    lp = clip32(lowpass_q + qmul(acc - lowpass_q, alpha_gain));
    hp = clip32(qmul(highpass_out_q + gyro_sum - highpass_in_q, alpha_gain));
    est = clip32(lp + hp);
    lowpass_q = lp;
    highpass_in_q = gyro_sum;
    highpass_out_q = hp;
    err = clip32(longint'(w.target_tilt) - est);
    e1 = err_hist[0];
    e2 = err_hist[1];
    y1 = duty_hist[0];
    y2 = duty_hist[1];
    err_hist[1] = e1;
    err_hist[0] = err;
    duty_hist[1] = y1;
    r.left_drive = '0;
    r.right_drive = '0;
    r.tilt_estimate = est[31:0];
    if (!stop) begin
      t = -qmul(fb1_gain, y1) - qmul(fb2_gain, y2) + qmul(ec0_gain, err) +
          qmul(ec1_gain, e1) + qmul(ec2_gain, e2);
      if (t >= One) duty = One;
      else if (t <= -One) duty = -One;
      else duty = t;
      duty_hist[0] = duty;
      r.left_drive = 32'(clip32(offset - duty));
      r.right_drive = 32'(clip32(duty + offset));
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    fault_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field,
             $signed(got), $signed(want));
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_count != 0) begin
      m_axis_tready <= 1'b0;
      hold_count <= hold_count - 1;
    end else if (hold_req) begin
      m_axis_tready <= 1'b0;
      hold_count <= 300;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted drive word with the oldest expectation
  always @(posedge clk) begin
    drive_word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected word", got.left_drive, 32'd0);
      end else begin
        want = expected_drives.pop_front();
        words_checked++;
        if (got.left_drive !== want.left_drive)
          report_mismatch("left_drive", got.left_drive, want.left_drive);
        if (got.right_drive !== want.right_drive)
          report_mismatch("right_drive", got.right_drive, want.right_drive);
        if (got.tilt_estimate !== want.tilt_estimate)
          report_mismatch("tilt_estimate", got.tilt_estimate, want.tilt_estimate);
      end
    end
  end

  // Offer one IMU word, with random idle cycles ahead of it
  task automatic send_imu(imu_word_t w, logic stop, logic typed, drive_word_t want);
    drive_word_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= stop;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_drives(w, stop);
    expected_drives.push_back(typed ? want : predicted);
    if (stop) stop_words++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_drives.size() != 0 || hold_count != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      RegFb1: fb1_gain = longint'($signed(data));
      RegFb2: fb2_gain = longint'($signed(data));
      RegEc0: ec0_gain = longint'($signed(data));
      RegEc1: ec1_gain = longint'($signed(data));
      RegEc2: ec2_gain = longint'($signed(data));
      RegAlpha: alpha_gain = longint'(data[16:0]);
      RegPeriod: period_gain = longint'(data[16:0]);
      default: ;
    endcase
  endtask

  task automatic load_gains(gains_t g);
    write_reg(RegFb1, g.fb1);
    write_reg(RegFb2, g.fb2);
    write_reg(RegEc0, g.ec0);
    write_reg(RegEc1, g.ec1);
    write_reg(RegEc2, g.ec2);
    write_reg(RegAlpha, g.alpha);
    write_reg(RegPeriod, g.period);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_gain();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(1048576) - 524288;
  endfunction

  function automatic gains_t gains_for_phase(int phase);
    gains_t g;
    g = '{-118797, 53261, -257207, 463602, -208581, 59578, 328};
    case (phase)
      1: g = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'd65536, 32'd65536};
      2: g = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h1ffff, 32'h1ffff};
      3: g = '{-118797, 53261, -257207, 463602, -208581, 0, 0};
      4, 6: g = '{rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                  $urandom_range(65536), $urandom_range(2000)};
      5: g = '{-118797, 53261, -257207, 463602, -208581, 32'hffffffff, 32'd65536};
      default: ;
    endcase
    return g;
  endfunction

  // Random IMU word: mostly plausible motion, sometimes full-range values
  function automatic imu_word_t rand_imu();
    imu_word_t w;
    w.accel_y = 16'($urandom);
    w.accel_z = 16'($urandom);
    case ($urandom_range(9))
      0: w.accel_y = 0;
      1: w.accel_z = 0;
      2: begin
        w.accel_y = 16'($urandom_range(40) - 20);
        w.accel_z = 16'($urandom_range(40) - 20);
      end
      default: ;
    endcase
    w.gyro_rate = ($urandom_range(9) < 7) ? $urandom_range(2621440) - 1310720 : $urandom;
    w.target_tilt = ($urandom_range(9) < 9) ? $urandom_range(1310720) - 655360 : $urandom;
    w.steer_offset = ($urandom_range(19) < 17) ? $urandom_range(65536) - 32768 : $urandom;
    return w;
  endfunction

  initial begin
    directed_row_t rows [$];
    drive_word_t none;
    none = '0;
    fb1_gain = -118797;
    fb2_gain = 53261;
    ec0_gain = -257207;
    ec1_gain = 463602;
    ec2_gain = -208581;
    alpha_gain = 59578;
    period_gain = 328;
    clear_history();

    // With zero alpha and zero gains the estimate is 0 and both drives carry the offset (zero on the stop row)
    rows = '{
      '{'{32'sh7fffffff, 32'sd0, 32'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b1,
        '{32'd0, 32'h7fffffff, 32'h7fffffff}},
      '{'{32'sh80000000, 32'sd0, 32'sh7fffffff, 16'sh7fff, 16'sh7fff}, 1'b0, 1'b1,
        '{32'd0, 32'h80000000, 32'h80000000}},
      '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, -16'sd32768, -16'sd32768}, 1'b1,
        1'b1, '{32'd0, 32'd0, 32'd0}},
      '{'{32'sd1234, 32'sh80000000, 32'sd0, 16'sd0, 16'sd100}, 1'b0, 1'b1,
        '{32'd0, 32'd1234, 32'd1234}},
      // default gains from here on, checked by the model
      '{'{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, 16'sh7fff, 16'sh7fff}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, -16'sd32768, -16'sd32768}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, -16'sd5, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, -16'sd5, -16'sd5}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, 16'sd1000, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd1000}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sd0, 16'sd0, -16'sd1000}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sh7fffffff, 16'sd9000, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sh7fffffff, 16'sd9000, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sd0, 32'sh80000000, 16'sd9000, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sh7fffffff, 32'sd0, 16'sd9000, -16'sd200}, 1'b0, 1'b0, none},
      '{'{32'sd0, 32'sh80000000, 32'sd0, 16'sd9000, 16'sd200}, 1'b0, 1'b0, none},
      '{'{32'sh7fffffff, 32'sh80000000, 32'sd0, 16'sd9000, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sh80000000, 32'sh7fffffff, 32'sd0, 16'sd9000, 16'sd0}, 1'b0, 1'b0, none},
      '{'{32'sd4096, 32'sd65536, 32'sd65536, 16'sd9000, 16'sd300}, 1'b1, 1'b0, none},
      '{'{32'sd4096, 32'sd65536, 32'sd65536, 16'sd9000, 16'sd300}, 1'b0, 1'b0, none}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: zero gains for the typed rows, then back to reset gains
    load_gains('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    foreach (rows[i]) begin
      if (i == 4) begin
        drain();
        load_gains(gains_for_phase(0));
      end
      send_imu(rows[i].imu, rows[i].stop, rows[i].typed, rows[i].want);
    end
    drain();

    // Random phases: new gains, rotating idle patterns
    for (int phase = 0; phase < PhaseCount; phase++) begin
      load_gains(gains_for_phase(phase));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < WordsPerPhase; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (phase == 4 && n == 3) hold_req <= 1'b1;
        if (phase == 4 && n == 4) hold_req <= 1'b0;
        send_imu(rand_imu(), ($urandom_range(9) == 0), 1'b0, none);
        // occasional pause until every drive word is back
        if (n == WordsPerPhase / 2) drain();
      end
      drain();
    end

    $display("checked %0d drive words (%0d with stop) over %0d gain settings,",
             words_checked, stop_words, PhaseCount + 2);
    $display("covering CORDIC quadrants, saturation, gain extremes and stalls");
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
